FILE: sv/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the LED blink sequencer: tick width, phase
// and command codes, and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Width of the free-running tick counter that stamps each item.
    localparam int TICK_WIDTH = 32;
    // Fixed widths of the configuration and result fields.
    localparam int PERIOD_W   = 32;
    localparam int LIMIT_W    = 32;
    localparam int BLINK_W    = 8;
    localparam int CNT_W      = BLINK_W + 1;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    // Elapsed time and wait limit are compared at the wider of the two widths.
    localparam int CMP_W      = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;
    // One quotient bit per divider step.
    localparam int DIV_STEPS  = PERIOD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef logic [TICK_WIDTH-1:0] t_tick;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_ON    = 2'd1,
        PH_WAIT_OFF   = 2'd2,
        PH_WAIT_DELAY = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK_COUNT    = 2'd0,
        CFG_PATTERN_PERIOD = 2'd1,
        CFG_REPEAT_DELAY   = 2'd2,
        CFG_REPEAT_ENABLE  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // register the accepted item
        logic exec;     // apply the item to the run state
        logic load;     // write the divided pattern into the run state
        logic emit;     // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the item needs the pattern interval computed
        logic div_done;  // the divider holds its final quotient
        logic out_free;  // the output register can take a new result
    } t_dp_status;

endpackage

FILE: sv/lbs_ctrl.sv
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencing state machine: takes one item, has the datapath apply it, waits
// for the divider when a pattern of nonzero blinks is loaded, and hands the result on.
// ----------------------------------------------------------------------------
module lbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lbs_pkg::t_dp_status i_status,
    output lbs_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_ready
);
    import lbs_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: sv/lbs_datapath.sv
// ----------------------------------------------------------------------------
// lbs_datapath
// Configuration registers, run state, elapsed-time compare, restoring divider
// for the step interval, and the output register.
// ----------------------------------------------------------------------------
module lbs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lbs_pkg::t_dp_cmd              i_cmd,
    output lbs_pkg::t_dp_status           o_status,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_now_ticks,
    input  logic                          i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_led_level,
    output logic                          o_led_changed,
    output logic [1:0]                    o_phase,
    output logic [8:0]                    o_transitions_left
);
    import lbs_pkg::*;

    // Configuration registers.
    logic [BLINK_W-1:0]  r_cfg_blinks;
    logic [PERIOD_W-1:0] r_cfg_period;
    logic [LIMIT_W-1:0]  r_cfg_delay;
    logic                r_cfg_repeat;

    // Captured item.
    logic [1:0] r_mode;
    t_tick      r_now;
    logic       r_led_before;

    // Run state.
    t_phase             r_phase,      n_phase;
    logic [CNT_W-1:0]   r_remaining,  n_remaining;
    logic [LIMIT_W-1:0] r_wait_limit, n_wait_limit;
    t_tick              r_last_stamp, n_last_stamp;
    logic               r_led,        n_led;

    // Divider.
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CNT_W-1:0]     r_div_rem;
    logic [PERIOD_W-1:0]  r_div_quo;
    logic [CNT_W:0]       div_trial;
    logic                 div_ge;

    // Output register.
    logic               r_o_valid;
    logic               r_o_led;
    logic               r_o_changed;
    t_phase             r_o_phase;
    logic [CNT_W-1:0]   r_o_remaining;

    logic [CNT_W-1:0] pattern_len;
    logic             blinks_zero;
    t_tick            elapsed;
    logic             timed;
    logic [CNT_W-1:0] rem_dec;
    logic             step_take;
    logic             need_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_blinks <= '0;
            r_cfg_period <= '0;
            r_cfg_delay  <= '0;
            r_cfg_repeat <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLINK_COUNT:    r_cfg_blinks <= i_cfg_data[BLINK_W-1:0];
                CFG_PATTERN_PERIOD: r_cfg_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_REPEAT_DELAY:   r_cfg_delay  <= i_cfg_data[LIMIT_W-1:0];
                CFG_REPEAT_ENABLE:  r_cfg_repeat <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= i_mode;
            r_now        <= TICK_WIDTH'(i_now_ticks);
            r_led_before <= r_led;
        end
    end

    assign pattern_len = {r_cfg_blinks, 1'b0};
    assign blinks_zero = (r_cfg_blinks == '0);
    assign elapsed     = r_now - r_last_stamp;
    assign timed       = (CMP_W'(elapsed) >= CMP_W'(r_wait_limit));
    assign rem_dec     = (r_remaining != '0) ? r_remaining - 1'b1 : '0;
    assign step_take   = (r_mode == MODE_UPDATE) && (r_phase != PH_IDLE) && timed;

    // A start always reloads; a timed step reloads at the end of a delay, or
    // at the end of a pattern that repeats without a delay.
    assign need_load = (r_mode == MODE_START) ||
                       (step_take && ((r_phase == PH_WAIT_DELAY) ||
                                      ((r_phase == PH_WAIT_OFF) && (rem_dec == '0) &&
                                       r_cfg_repeat && (r_cfg_delay == '0))));

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_wait_limit = r_wait_limit;
        n_last_stamp = r_last_stamp;
        n_led        = r_led;
        if (i_cmd.exec) begin
            if (r_mode == MODE_START) begin
                n_last_stamp = r_now;
            end else if (r_mode == MODE_STOP) begin
                n_led        = 1'b0;
                n_phase      = PH_IDLE;
                n_remaining  = '0;
                n_wait_limit = '0;
                n_last_stamp = '0;
            end else if (step_take) begin
                n_last_stamp = r_now;
                unique case (r_phase)
                    PH_WAIT_ON: begin
                        n_led       = 1'b1;
                        n_remaining = rem_dec;
                        n_phase     = PH_WAIT_OFF;
                    end
                    PH_WAIT_OFF: begin
                        n_led       = 1'b0;
                        n_remaining = rem_dec;
                        if (rem_dec != '0) begin
                            n_phase = PH_WAIT_ON;
                        end else if (!r_cfg_repeat) begin
                            n_phase = PH_IDLE;
                        end else if (r_cfg_delay != '0) begin
                            n_wait_limit = r_cfg_delay;
                            n_phase      = PH_WAIT_DELAY;
                        end
                    end
                    PH_WAIT_DELAY, PH_IDLE: begin
                    end
                endcase
            end
            // A pattern of zero blinks is loaded without dividing.
            if (need_load && blinks_zero) begin
                n_remaining  = '0;
                n_wait_limit = '0;
                n_phase      = PH_IDLE;
            end
        end
        if (i_cmd.load) begin
            n_remaining  = pattern_len;
            n_wait_limit = r_div_quo;
            n_phase      = PH_WAIT_ON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_remaining  <= '0;
            r_wait_limit <= '0;
            r_last_stamp <= '0;
            r_led        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_wait_limit <= n_wait_limit;
            r_last_stamp <= n_last_stamp;
            r_led        <= n_led;
        end
    end

    // Restoring divider: one quotient bit per cycle, period / pattern_len.
    assign div_trial = {r_div_rem, r_div_quo[PERIOD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, pattern_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.exec && need_load && !blinks_zero) begin
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_div_rem <= '0;
            r_div_quo <= r_cfg_period;
        end else if (r_div_cnt != '0) begin
            r_div_rem <= div_ge ? CNT_W'(div_trial - {1'b0, pattern_len})
                                : CNT_W'(div_trial);
            r_div_quo <= {r_div_quo[PERIOD_W-2:0], div_ge};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_led       <= r_led;
            r_o_changed   <= (r_led != r_led_before);
            r_o_phase     <= r_phase;
            r_o_remaining <= r_remaining;
        end
    end

    assign o_status.need_div = need_load && !blinks_zero;
    assign o_status.div_done = (r_div_cnt == '0);
    assign o_status.out_free = !r_o_valid || !i_stall;

    assign o_valid            = r_o_valid;
    assign o_led_level        = r_o_led;
    assign o_led_changed      = r_o_changed;
    assign o_phase            = 2'(r_o_phase);
    assign o_transitions_left = r_o_remaining;

endmodule

FILE: sv/led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// led_blink_sequencer
// Divide: a start or restart with a nonzero blink count waits on the 32-step
//   divider; other items do not.
// Throughput: one item at a time; the next item can be taken only after the
//   result is loaded into the output register.
// Reset: synchronous, active low; LED off, phase idle, config and run state zero.
// ----------------------------------------------------------------------------
// Each item is a command (update, start or stop) stamped with the current
// value of a free-running tick counter. A start records the stamp and loads
// twice the blink count as the number of LED transitions left; the wait
// between transitions is the pattern period divided by that number. Each
// update whose wrapped elapsed time has reached the wait limit takes a
// timed step: the LED toggles and the count drops. At the end of a pattern
// the block goes idle, or in repeat mode waits the repeat delay (if set) and
// loads the pattern again. A stop switches the LED off and clears the run
// state. Every item yields exactly one result that reports the state after
// the item.
//
// The controller walks each item through capture, execution, an optional
// divide and delivery. The divider is a restoring divider that produces one
// quotient bit per cycle, so any item that loads a pattern with a nonzero
// blink count waits in the divide state until the quotient is complete. The
// output register holds a finished result while the downstream side stalls.
// ----------------------------------------------------------------------------
module led_blink_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_now_ticks,
    // Result item channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_led_level,
    output logic        o_led_changed,
    output logic [1:0]  o_phase,
    output logic [8:0]  o_transitions_left,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lbs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    // The input side is ready only while the controller waits for an item.
    assign o_stall = !in_ready;

    lbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_ready (in_ready)
    );

    lbs_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_mode             (i_mode),
        .i_now_ticks        (i_now_ticks),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_led_level        (o_led_level),
        .o_led_changed      (o_led_changed),
        .o_phase            (o_phase),
        .o_transitions_left (o_transitions_left)
    );

endmodule

FILE: sv/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the LED blink sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_led_level,
    input logic        o_led_changed,
    input logic [1:0]  o_phase,
    input logic [8:0]  o_transitions_left
);
    import lbs_pkg::*;

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_led_level) &&
        $stable(o_led_changed) && $stable(o_phase) && $stable(o_transitions_left))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted while one is in work");

    // Every path into idle leaves no transitions pending.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == PH_IDLE) |-> (o_transitions_left == '0))
        else $error("idle with transitions left");

    // Waiting to switch off means the LED is on; waiting the delay means off.
    a_led_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_phase != PH_WAIT_OFF) || o_led_level) &&
                    ((o_phase != PH_WAIT_DELAY) || !o_led_level))
        else $error("LED level does not match phase");

endmodule

bind led_blink_sequencer lbs_checker u_lbs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_led_level        (o_led_level),
    .o_led_changed      (o_led_changed),
    .o_phase            (o_phase),
    .o_transitions_left (o_transitions_left)
);
